// ===== src/reverse_in_groups_unit_defines.svh =====
// Assertion macros shared by the reverse-in-groups checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef REVERSE_IN_GROUPS_UNIT_DEFINES_SVH
`define REVERSE_IN_GROUPS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RIG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RIG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rig_pkg.sv =====
// Shared types and constants for the reverse-in-groups unit.
// No dependencies; every other file of the block but the macro header imports it.
package rig_pkg;

    // Width of one element value.
    localparam int VALUE_W = 32;

    // Width of the group size register.
    localparam int GSIZE_W = 5;

    // Default depth of the group store.
    localparam int MAX_GROUP_DEF = 16;

    // Reset value of the group size register.
    localparam logic [GSIZE_W-1:0] GSIZE_RST = GSIZE_W'(1);

    // Marks that travel with each result.
    typedef struct packed {
        logic run_last;
        logic list_done;
    } rig_tag_t;

endpackage

// ===== src/rig_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// Depends on rig_pkg for the value width.
interface rig_in_if
    import rig_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      end_of_list;

    modport source (output valid, output value, output end_of_list, input ready);
    modport sink   (input valid, input value, input end_of_list, output ready);
endinterface

interface rig_out_if
    import rig_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] out_value;
    logic                      run_last;
    logic                      list_done;

    modport source (output valid, output out_value, output run_last, output list_done,
                    input ready);
    modport sink   (input valid, input out_value, input run_last, input list_done,
                    output ready);
endinterface

// ===== src/reverse_in_groups_unit.sv =====
// Reverse-in-groups unit: an item that does not close a group is only stored.
// An item that closes a group of n values or ends the list holds ready low while the
// single read port of the group store fetches one value per cycle while the output
// register can take it; results pass the read and output registers, one per cycle
// unless the sink stalls. Reset clears control state and sets group_size to 1; the
// group store keeps stale data, and no entry is read before it is written.
module reverse_in_groups_unit
    import rig_pkg::*;
#(
    parameter int MAX_GROUP = MAX_GROUP_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [GSIZE_W-1:0] cfg_wr_data,
    rig_in_if.sink             items,
    rig_out_if.source          results
);

    localparam int IDX_W = $clog2(MAX_GROUP);
    localparam int CNT_W = $clog2(MAX_GROUP + 1);
    localparam int CMP_W = (CNT_W > GSIZE_W) ? CNT_W : GSIZE_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } rig_state_t;

    rig_state_t         state_reg, state_next;
    logic [GSIZE_W-1:0] gsize_reg;
    logic [IDX_W-1:0]   fill_reg, fill_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic               rev_reg, rev_next;
    logic               end_reg, end_next;
    logic               rd_valid_reg, rd_valid_next;
    rig_tag_t           rd_tag_reg;
    logic signed [VALUE_W-1:0] rd_data_reg;

    logic signed [VALUE_W-1:0] group_store_mem [MAX_GROUP];

    logic             in_xfer;
    logic [CMP_W-1:0] gs_w, g_eff, n_w;
    logic             close_group;
    logic             rd_take, rd_go, rd_last;

    // Group size register; users keep it written only while the unit is idle; unchecked.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gsize_reg <= GSIZE_RST;
        end
        else if (cfg_wr_en)
        begin
            gsize_reg <= cfg_wr_data;
        end
    end

    assign items.ready = (state_reg == ST_IDLE);
    assign in_xfer     = items.valid && items.ready;

    // Effective group size: zero acts as one, larger values saturate at the store depth.
    always_comb
    begin
        gs_w = CMP_W'(gsize_reg);
        if (gs_w == '0)
        begin
            g_eff = CMP_W'(1);
        end
        else if (gs_w > CMP_W'(MAX_GROUP))
        begin
            g_eff = CMP_W'(MAX_GROUP);
        end
        else
        begin
            g_eff = gs_w;
        end
    end

    assign n_w         = CMP_W'(fill_reg) + CMP_W'(1);
    assign close_group = (n_w >= g_eff);

    // Read pipeline: a fetch may start when the read stage is empty or drains now.
    assign rd_go   = (state_reg == ST_EMIT) && (!rd_valid_reg || rd_take);
    assign rd_last = (rem_reg == CNT_W'(1));

    // Group store: one write port for arriving values, one registered read port.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            group_store_mem[fill_reg] <= items.value;
        end
        if (rd_go)
        begin
            rd_data_reg <= group_store_mem[idx_reg];
            rd_tag_reg  <= '{run_last: rd_last, list_done: rd_last && end_reg};
        end
    end

    // Sequencer: fill on each transfer, then walk the store forward or backward.
    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        idx_next      = idx_reg;
        rem_next      = rem_reg;
        rev_next      = rev_reg;
        end_next      = end_reg;
        rd_valid_next = rd_go ? 1'b1 : (rd_take ? 1'b0 : rd_valid_reg);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (close_group || items.end_of_list)
                    begin
                        state_next = ST_EMIT;
                        fill_next  = '0;
                        rem_next   = CNT_W'(fill_reg) + CNT_W'(1);
                        rev_next   = close_group;
                        idx_next   = close_group ? fill_reg : '0;
                        end_next   = items.end_of_list;
                    end
                    else
                    begin
                        fill_next = fill_reg + IDX_W'(1);
                    end
                end
            end
            ST_EMIT:
            begin
                if (rd_go)
                begin
                    rem_next = rem_reg - CNT_W'(1);
                    idx_next = rev_reg ? (idx_reg - IDX_W'(1)) : (idx_reg + IDX_W'(1));
                    if (rd_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            idx_reg      <= '0;
            rem_reg      <= '0;
            rev_reg      <= 1'b0;
            end_reg      <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            idx_reg      <= idx_next;
            rem_reg      <= rem_next;
            rev_reg      <= rev_next;
            end_reg      <= end_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    // Output register toward the result sink.
    rig_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (rd_valid_reg),
        .load_ready (rd_take),
        .load_value (rd_data_reg),
        .load_tag   (rd_tag_reg),
        .results    (results)
    );

endmodule

// ===== src/rig_out_stage.sv =====
// Output register of the reverse-in-groups unit.
// Depends on rig_pkg and rig_out_if; decouples the read pipeline from the result sink.
module rig_out_stage
    import rig_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load_valid,
    output logic                      load_ready,
    input  logic signed [VALUE_W-1:0] load_value,
    input  rig_tag_t                  load_tag,
    rig_out_if.source                 results
);

    logic                      valid_reg;
    logic signed [VALUE_W-1:0] value_reg;
    rig_tag_t                  tag_reg;

    // The register can take new data when empty or when its content leaves now.
    assign load_ready = !valid_reg || results.ready;

    // Valid flag of the held result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load_ready)
        begin
            valid_reg <= load_valid;
        end
    end

    // Payload of the held result.
    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
        begin
            value_reg <= load_value;
            tag_reg   <= load_tag;
        end
    end

    assign results.valid     = valid_reg;
    assign results.out_value = value_reg;
    assign results.run_last  = tag_reg.run_last;
    assign results.list_done = tag_reg.list_done;

endmodule

// ===== src/rig_checker.sv =====
// Port-level checks for the reverse-in-groups unit, bound to the top level.
// Depends on rig_pkg and the assertion macros in reverse_in_groups_unit_defines.svh.
`include "reverse_in_groups_unit_defines.svh"

module rig_checker
    import rig_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      in_end,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [VALUE_W-1:0] out_value,
    input logic                      out_run_last,
    input logic                      out_list_done
);

    // A stalled result keeps its value and marks until the transfer.
    `RIG_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_run_last) && $stable(out_list_done), "stalled result changed")

    // The end of the list is always the last result of its item.
    `RIG_ASSERT_IMP(a_done_is_last, out_valid && out_list_done, out_run_last, "list_done without run_last")

    // An item with the end mark always flushes, so the unit is busy next cycle.
    `RIG_ASSERT_NXT(a_end_flushes, in_valid && in_ready && in_end, !in_ready, "end mark did not start a flush")

endmodule

bind reverse_in_groups_unit rig_checker u_rig_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (items.valid),
    .in_ready      (items.ready),
    .in_end        (items.end_of_list),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .out_value     (results.out_value),
    .out_run_last  (results.run_last),
    .out_list_done (results.list_done)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for reverse_in_groups_unit: random lists are reordered by a predictor.
// Every result transfer is compared with the predicted order. Needs rig_pkg, rig_if.sv and the RTL.
module testbench;
    import rig_pkg::*;

    // Cycles the block may still be busy after the last result of a burst.
    localparam int LATENCY_CYCLES = 4;
    // Cycles without any transfer before the run is declared hung.
    localparam int QUIET_LIMIT    = 2000;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      end_of_list;
    } list_item_t;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      run_last;
        logic                      list_done;
    } reordered_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [GSIZE_W-1:0] cfg_wr_data;

    rig_in_if  item_bus ();
    rig_out_if result_bus ();

    reverse_in_groups_unit #(
        .MAX_GROUP (MAX_GROUP_DEF)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .items       (item_bus),
        .results     (result_bus)
    );

    // Predictor state: held values, their count, and the group size register.
    logic signed [VALUE_W-1:0] held_values [MAX_GROUP_DEF];
    int unsigned               held_count = 0;
    logic [GSIZE_W-1:0]        group_size_reg = GSIZE_RST;

    list_item_t  pending_items [$];
    reordered_t  reordered_q [$];

    bit          idling_on    = 1'b1;
    bit          item_taken   = 1'b0;
    int unsigned send_gap     = 0;
    int unsigned stall_left   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned error_count  = 0;
    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned size_writes  = 0;

    // Clock: 10 ns period.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Known values on every input from time zero.
    initial
    begin
        rst_n                  = 1'b0;
        cfg_wr_en              = 1'b0;
        cfg_wr_data            = '0;
        item_bus.valid         = 1'b0;
        item_bus.value         = '0;
        item_bus.end_of_list   = 1'b0;
        result_bus.ready       = 1'b0;
    end

    // Works out the results that one accepted item causes.
    function automatic void reorder_item(logic signed [VALUE_W-1:0] v, logic eol);
        int unsigned eff;
        int unsigned n;
        reordered_t  r;
        eff = 32'(group_size_reg);
        if (eff < 1)
            eff = 1;
        if (eff > MAX_GROUP_DEF)
            eff = MAX_GROUP_DEF;
        held_values[held_count] = v;
        n = held_count + 1;
        if (n >= eff)
        begin
            // A full group leaves newest first.
            for (int i = n - 1; i >= 0; i--)
            begin
                r.value     = held_values[i];
                r.run_last  = (i == 0);
                r.list_done = eol && (i == 0);
                reordered_q.push_back(r);
            end
            held_count = 0;
        end
        else if (eol)
        begin
            // A partial group at the end of the list keeps its arrival order.
            for (int i = 0; i < n; i++)
            begin
                r.value     = held_values[i];
                r.run_last  = (i == n - 1);
                r.list_done = (i == n - 1);
                reordered_q.push_back(r);
            end
            held_count = 0;
        end
        else
            held_count = n;
    endfunction

    task automatic report_mismatch(string what, logic [VALUE_W-1:0] want,
                                   logic [VALUE_W-1:0] got);
        $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
        error_count++;
    endtask

    // Sender: presents queued items at the falling edge, with random gaps while idling_on is set.
    always @(negedge clk)
    begin : item_driver
        logic       nxt_valid;
        list_item_t nxt;
        if (rst_n)
        begin
            nxt_valid  = item_bus.valid && !item_taken;
            item_taken = 1'b0;
            if (!nxt_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_items.size() > 0)
                begin
                    nxt = pending_items.pop_front();
                    item_bus.value       <= nxt.value;
                    item_bus.end_of_list <= nxt.end_of_list;
                    nxt_valid = 1'b1;
                    if (idling_on && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 8);
                end
            end
            item_bus.valid <= nxt_valid;
        end
    end

    // Receiver: ready drops in random stall bursts that start only while idling_on is set.
    always @(negedge clk)
    begin : result_stall
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                result_bus.ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 7);
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    // Transfer monitor: predicts on each input transfer, checks each result transfer.
    always @(posedge clk)
    begin : transfer_monitor
        reordered_t want;
        bit         moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (item_bus.valid && item_bus.ready)
            begin
                reorder_item(item_bus.value, item_bus.end_of_list);
                item_taken = 1'b1;
                items_sent++;
                moved = 1'b1;
            end
            if (result_bus.valid && result_bus.ready)
            begin
                results_seen++;
                moved = 1'b1;
                if (reordered_q.size() == 0)
                    report_mismatch("unexpected result", '0, result_bus.out_value);
                else
                begin
                    want = reordered_q.pop_front();
                    if (result_bus.out_value !== want.value)
                        report_mismatch("out_value", want.value, result_bus.out_value);
                    if (result_bus.run_last !== want.run_last)
                        report_mismatch("run_last", VALUE_W'(want.run_last),
                                        VALUE_W'(result_bus.run_last));
                    if (result_bus.list_done !== want.list_done)
                        report_mismatch("list_done", VALUE_W'(want.list_done),
                                        VALUE_W'(result_bus.list_done));
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    // Watchdog on cycles without any transfer.
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("Hung after %0d cycles without a transfer.", QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    task automatic queue_item(logic signed [VALUE_W-1:0] v, logic eol);
        list_item_t it;
        it.value       = v;
        it.end_of_list = eol;
        pending_items.push_back(it);
    endtask

    // Holds the sender until every expected result is in and the block has settled.
    task automatic wait_idle();
        while (pending_items.size() > 0 || item_bus.valid || reordered_q.size() > 0)
            @(posedge clk);
        repeat (LATENCY_CYCLES) @(posedge clk);
    endtask

    task automatic write_group_size(logic [GSIZE_W-1:0] sz);
        wait_idle();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= sz;
        @(negedge clk);
        cfg_wr_en      <= 1'b0;
        group_size_reg  = sz;
        size_writes++;
    endtask

    // Mostly random values, with the extremes mixed in.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // One setting: whole lists of random length, sometimes a dangling tail.
    task automatic queue_random_lists(logic [GSIZE_W-1:0] sz, int unsigned quota);
        int unsigned eff;
        int unsigned len;
        int unsigned count;
        eff = (sz < 1) ? 1 : (sz > MAX_GROUP_DEF) ? MAX_GROUP_DEF : sz;
        count = 0;
        write_group_size(sz);
        while (count < quota)
        begin
            len = $urandom_range(1, 3 * eff + 1);
            for (int j = 0; j < len; j++)
                queue_item(pick_value(), j == len - 1);
            count += len;
        end
        if ($urandom_range(0, 1) == 1)
        begin
            len = $urandom_range(1, eff);
            for (int j = 0; j < len; j++)
                queue_item(pick_value(), 1'b0);
        end
    endtask

    // Stimulus sequence.
    initial
    begin
        logic [GSIZE_W-1:0] sizes [10];
        sizes = '{5'd16, 5'd31, 5'd2, 5'd0, 5'd17, 5'd1, 5'd5, 5'd0, 5'd0, 5'd0};
        for (int p = 7; p < 10; p++)
            sizes[p] = GSIZE_W'($urandom_range(1, 16));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset size passes values straight through, extremes included.
        queue_item(32'h8000_0000, 1'b0);
        queue_item(32'h7FFF_FFFF, 1'b1);
        queue_item(32'h0000_0000, 1'b0);
        queue_item(32'hFFFF_FFFF, 1'b1);

        // Full group reversed, then a partial group kept in order at the end mark.
        write_group_size(5'd4);
        for (int i = 1; i <= 7; i++)
            queue_item(i, i == 7);

        // End mark landing on a full group.
        for (int i = 11; i <= 14; i++)
            queue_item(i, i == 14);

        // Size zero behaves as pass-through.
        write_group_size(5'd0);
        queue_item(32'h1234_5678, 1'b0);
        queue_item(32'h8765_4321, 1'b1);

        // Size lowered while values are held: everything held leaves reversed.
        write_group_size(5'd8);
        for (int i = 21; i <= 25; i++)
            queue_item(i, 1'b0);
        write_group_size(5'd3);
        queue_item(26, 1'b0);

        // Random lists over several settings; the last ones run without idling.
        for (int p = 0; p < 10; p++)
        begin
            if (p == 8)
            begin
                wait_idle();
                idling_on = 1'b0;
            end
            queue_random_lists(sizes[p], 27);
        end

        wait_idle();
        $display("Covered %0d items in %0d group-size settings, including 0 and above 16.",
                 items_sent, size_writes + 1);
        $display("Compared %0d result transfers; %0d mismatches.", results_seen, error_count);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/rig_pkg.sv
src/rig_if.sv
src/rig_out_stage.sv
src/reverse_in_groups_unit.sv
src/rig_checker.sv
sim/testbench.sv
